>>> hw/rtl/bmp_fb_pkg.sv
// Shared types and constants for the BMP pixel stream to framebuffer block.
// Used by bmp_fb_unpack, bmp_fb_addr and bmp_pixel_stream_to_framebuffer.
`default_nettype none

package bmp_fb_pkg;

   // Default screen geometry.
   localparam int DEFAULT_SCREEN_WIDTH  = 800;
   localparam int DEFAULT_SCREEN_HEIGHT = 480;

   // Largest image dimension handled.
   localparam logic [11:0] MAX_DIM = 12'd2048;

   // Register reset values.
   localparam logic [11:0] RESET_IMAGE_WIDTH  = 12'd800;
   localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd480;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_IS_32  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd4;

   // Field widths of the result item.
   localparam int ADDR_W  = 19;
   localparam int COLOR_W = 32;

   // Width of screen coordinates carried between stages.
   localparam int COORD_W = 12;

   // Configuration registers as one bundle.
   typedef struct packed {
      logic [11:0]        image_width;
      logic signed [12:0] image_height;
      logic               depth_is_32;
      logic [9:0]         origin_x;
      logic [9:0]         origin_y;
   } cfg_type;

   // One finished pixel, before the address is formed.
   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic               visible;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   // One result item.
   typedef struct packed {
      logic [ADDR_W-1:0]  write_address;
      logic [COLOR_W-1:0] argb_color;
      logic               visible;
      logic               last_pixel;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/bmp_fb_unpack.sv
// Byte gatherer, row and column tracking and screen placement of each pixel.
// Depends on bmp_fb_pkg; feeds bmp_fb_addr through a registered pixel stage.
`default_nettype none

module bmp_fb_unpack #(
   parameter int SCREEN_WIDTH  = bmp_fb_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = bmp_fb_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bmp_fb_pkg::cfg_type   cfg,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_byte,
   output logic                       in_ready,
   output logic                       pix_valid,
   output bmp_fb_pkg::pixel_type      pix,
   input  wire logic                  pix_ready
);

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] partial_ff, partial_in;
   logic [10:0] col_ff, col_in;
   logic [10:0] row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;
   logic        finished_ff, finished_in;
   logic        pix_valid_ff, pix_valid_in;
   bmp_fb_pkg::pixel_type pix_ff, pix_in;

   logic [11:0] w_eff;
   logic [12:0] h_mag;
   logic [11:0] ah;
   logic        gather;
   logic        row_end;
   logic        img_end;
   logic [11:0] sx;
   logic [13:0] sy;
   logic        vis;
   logic        in_fire;

   // The pixel stage takes a new item when empty or when its item leaves.
   assign in_ready = !pix_valid_ff || pix_ready;
   assign in_fire  = in_valid && in_ready;

   // Effective image geometry and the placement of the current pixel.
   always_comb begin
      if (cfg.image_width == 12'd0) begin
         w_eff = 12'd1;
      end else if (cfg.image_width > bmp_fb_pkg::MAX_DIM) begin
         w_eff = bmp_fb_pkg::MAX_DIM;
      end else begin
         w_eff = cfg.image_width;
      end

      h_mag = cfg.image_height[12] ? (~cfg.image_height + 13'd1) : cfg.image_height;
      ah    = (h_mag > 13'(bmp_fb_pkg::MAX_DIM)) ? bmp_fb_pkg::MAX_DIM : h_mag[11:0];

      // 32-bit pixels gather three bytes, 24-bit pixels two.
      gather  = cfg.depth_is_32 ? (phase_ff != 2'd3) : (phase_ff < 2'd2);

      row_end = ({1'b0, col_ff} + 12'd1) >= w_eff;
      img_end = row_end && (({1'b0, row_ff} + 12'd1) >= ah);

      // Bottom-up images are flipped; sy may go negative.
      sx = 12'(cfg.origin_x) + 12'(col_ff);
      if (cfg.image_height[12]) begin
         sy = 14'(cfg.origin_y) + 14'(row_ff);
      end else begin
         sy = 14'(cfg.origin_y) + 14'(ah) - 14'd1 - 14'(row_ff);
      end
      vis = ({1'b0, sx} < 13'(SCREEN_WIDTH)) && !sy[13]
            && (sy[12:0] < 13'(SCREEN_HEIGHT));
   end

   // Stream state update and the pixel register.
   always_comb begin
      phase_in     = phase_ff;
      partial_in   = partial_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pad_in       = pad_ff;
      finished_in  = finished_ff;
      pix_valid_in = pix_valid_ff && !pix_ready;
      pix_in       = pix_ff;

      if (in_fire && !finished_ff && (ah != 12'd0)) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else if (gather) begin
            case (phase_ff)
               2'd0:    partial_in = partial_ff | {16'd0, in_byte};
               2'd1:    partial_in = partial_ff | {8'd0, in_byte, 8'd0};
               2'd2:    partial_in = partial_ff | {in_byte, 16'd0};
               default: partial_in = partial_ff;
            endcase
            phase_in = phase_ff + 2'd1;
         end else begin
            // Final byte: alpha for 32-bit pixels, red for 24-bit ones.
            pix_valid_in = 1'b1;
            pix_in.sx      = sx;
            pix_in.sy      = sy[11:0];
            pix_in.visible = vis;
            pix_in.last    = img_end;
            if (cfg.depth_is_32) begin
               pix_in.color = {in_byte, partial_ff};
            end else begin
               pix_in.color = {8'd0, partial_ff | {in_byte, 16'd0}};
            end
            phase_in   = 2'd0;
            partial_in = 24'd0;
            if (img_end) begin
               finished_in = 1'b1;
            end else if (row_end) begin
               col_in = 11'd0;
               row_in = row_ff + 11'd1;
               // 24-bit rows need width mod 4 bytes of padding.
               pad_in = cfg.depth_is_32 ? 2'd0 : w_eff[1:0];
            end else begin
               col_in = col_ff + 11'd1;
            end
         end
      end
   end

   // Control state is cleared at reset; the pixel payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         partial_ff   <= 24'd0;
         col_ff       <= 11'd0;
         row_ff       <= 11'd0;
         pad_ff       <= 2'd0;
         finished_ff  <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         partial_ff   <= partial_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
         finished_ff  <= finished_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

`ifndef SYNTHESIS
   // Once the image is done the block stays done until reset.
   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("image finished flag cleared without reset");

   // Row padding is only skipped between whole pixels.
   a_pad_between_pixels: assert property (@(posedge clock) disable iff (reset)
      (pad_ff != 2'd0) |-> (phase_ff == 2'd0))
      else $error("padding pending in the middle of a pixel");

   // A final pixel in the stage means the image has been closed.
   a_last_closes_image: assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && pix_ff.last) |-> finished_ff)
      else $error("last pixel issued without finishing the image");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/bmp_fb_addr.sv
// Framebuffer address stage and result register (row * screen width + column).
// Depends on bmp_fb_pkg; takes pixels from bmp_fb_unpack.
`default_nettype none

module bmp_fb_addr #(
   parameter int SCREEN_WIDTH = bmp_fb_pkg::DEFAULT_SCREEN_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pix_valid,
   input  wire bmp_fb_pkg::pixel_type pix,
   output logic                       pix_ready,
   output logic                       res_valid,
   output bmp_fb_pkg::result_type     res,
   input  wire logic                  res_ready
);

   localparam int PROD_W = 2 * bmp_fb_pkg::COORD_W + 1;

   logic                   res_valid_ff, res_valid_in;
   bmp_fb_pkg::result_type res_ff, res_in;
   logic [PROD_W-1:0]      linear;

   assign pix_ready = !res_valid_ff || res_ready;

   // Linear word index; off-screen pixels report address zero.
   always_comb begin
      linear = PROD_W'(pix.sy) * PROD_W'(SCREEN_WIDTH) + PROD_W'(pix.sx);

      res_valid_in = res_valid_ff && !res_ready;
      res_in       = res_ff;
      if (pix_valid && pix_ready) begin
         res_valid_in         = 1'b1;
         res_in.write_address = pix.visible ? linear[bmp_fb_pkg::ADDR_W-1:0]
                                            : '0;
         res_in.argb_color    = pix.color;
         res_in.visible       = pix.visible;
         res_in.last_pixel    = pix.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bmp_pixel_stream_to_framebuffer.sv
// Top level: BMP pixel byte stream in, framebuffer writes out.
// Depends on bmp_fb_pkg, bmp_fb_unpack and bmp_fb_addr.
//
// Usage. The req channel takes the BMP pixel array one byte per item,
// row padding included. The rsp channel gives one item per finished pixel:
// word address, ARGB colour, a visible flag in tuser and tlast on the final
// pixel of the image. Bytes after the final pixel are taken and dropped.
// The csr channel writes the header values (width, height, depth, origin);
// it is always ready. The user must write it only while no pixel is in
// flight; the block itself does not enforce this. A pixel's result is
// held first in the pixel register, loaded at the edge that takes the
// pixel's last byte, and then in the result register of the address stage.
// Throughput: one byte per cycle while req_tready is high, set by the
// single pass through the byte gatherer; each stage advances when the
// stage after it is empty or being emptied. Reset clears the stream
// position and loads the header defaults (800 x 480, 24-bit, origin 0,0).
// When the receiver stalls, the result register holds, then the pixel
// register fills, and req_tready falls only once both are occupied.
`default_nettype none

module bmp_pixel_stream_to_framebuffer #(
   parameter int SCREEN_WIDTH  = bmp_fb_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = bmp_fb_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Fields from bit 0: pixel_byte[7:0].
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: write_address[18:0], argb_color[50:19], zero fill.
   output logic [55:0]                            rsp_tdata,
   // Fields from bit 0: visible.
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bmp_fb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bmp_fb_pkg::CSR_DATA_W-1:0]  csr_data
);

   bmp_fb_pkg::cfg_type    cfg_ff, cfg_in;
   bmp_fb_pkg::pixel_type  pix;
   bmp_fb_pkg::result_type res;
   logic                   pix_valid;
   logic                   pix_ready;

   assign csr_ready = 1'b1;

   // Header register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bmp_fb_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[11:0];
            bmp_fb_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data[12:0];
            bmp_fb_pkg::REG_DEPTH_IS_32:  cfg_in.depth_is_32  = csr_data[0];
            bmp_fb_pkg::REG_ORIGIN_X:     cfg_in.origin_x     = csr_data[9:0];
            bmp_fb_pkg::REG_ORIGIN_Y:     cfg_in.origin_y     = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= bmp_fb_pkg::RESET_IMAGE_WIDTH;
         cfg_ff.image_height <= bmp_fb_pkg::RESET_IMAGE_HEIGHT;
         cfg_ff.depth_is_32  <= 1'b0;
         cfg_ff.origin_x     <= 10'd0;
         cfg_ff.origin_y     <= 10'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmp_fb_unpack #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_ready  (req_tready),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready)
   );

   bmp_fb_addr #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .res_valid (rsp_tvalid),
      .res       (res),
      .res_ready (rsp_tready)
   );

   // Result packing.
   assign rsp_tdata = {5'd0, res.argb_color, res.write_address};
   assign rsp_tuser = res.visible;
   assign rsp_tlast = res.last_pixel;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for bmp_pixel_stream_to_framebuffer.
// Drives BMP pixel bytes and header registers, predicts every pixel write
// in a behavioural model of its own, and checks each one. Needs bmp_fb_pkg.
module tb_top;

   localparam int SCREEN_W     = bmp_fb_pkg::DEFAULT_SCREEN_WIDTH;
   localparam int SCREEN_H     = bmp_fb_pkg::DEFAULT_SCREEN_HEIGHT;
   localparam int DIM_LIMIT    = 2048;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_BYTES = 1850;
   localparam int LIMIT_CYCLES = 400000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                               clock;
   logic                               reset      = 1'b1;
   logic [7:0]                         req_tdata  = 8'h00;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [55:0]                        rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [bmp_fb_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [bmp_fb_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // Header registers as the block should hold them.
   logic [11:0]        cfg_width    = bmp_fb_pkg::RESET_IMAGE_WIDTH;
   logic signed [12:0] cfg_height   = bmp_fb_pkg::RESET_IMAGE_HEIGHT;
   logic               cfg_depth32  = 1'b0;
   logic [9:0]         cfg_origin_x = 10'd0;
   logic [9:0]         cfg_origin_y = 10'd0;

   // Stream position as the block should hold it.
   logic [1:0]  byte_pos   = 2'd0;
   logic [23:0] gathered   = 24'd0;
   logic [10:0] col_cnt    = 11'd0;
   logic [10:0] row_cnt    = 11'd0;
   logic [1:0]  pad_left   = 2'd0;
   logic        image_done = 1'b0;

   bmp_fb_pkg::result_type expected_pixels[$];

   int send_gap_pct   = 0;
   int stall_pct      = 0;
   int hold_requests  = 0;
   int hold_grants    = 0;
   int hold_left      = 0;
   int bytes_sent     = 0;
   int pixels_checked = 0;
   int pixels_visible = 0;
   int phases_run     = 0;
   int mismatches     = 0;
   int cycles         = 0;

   bmp_pixel_stream_to_framebuffer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the blit by one byte; returns 1 when a pixel write results.
   function automatic bit blit_byte(input logic [7:0] value,
                                    output bmp_fb_pkg::result_type px);
      int w, h, ah, bpp, col, row, sx, sy;
      bit row_end, img_end, vis;
      logic [7:0] alpha;
      px    = '0;
      alpha = 8'h00;
      w = int'(cfg_width);
      if (w < 1) w = 1;
      if (w > DIM_LIMIT) w = DIM_LIMIT;
      h  = cfg_height;
      ah = (h < 0) ? -h : h;
      if (ah > DIM_LIMIT) ah = DIM_LIMIT;
      bpp = cfg_depth32 ? 4 : 3;
      if (image_done || ah == 0) return 1'b0;
      // Row padding is swallowed without a result.
      if (pad_left != 2'd0) begin
         pad_left = pad_left - 2'd1;
         return 1'b0;
      end
      // Blue, green and, for 32-bit pixels, red are gathered.
      if (byte_pos < 2'd3 && int'(byte_pos) + 1 < bpp) begin
         gathered = gathered | (24'(value) << (8 * byte_pos));
         byte_pos = byte_pos + 2'd1;
         return 1'b0;
      end
      if (bpp == 4) begin
         alpha = value;
      end else begin
         gathered[23:16] = gathered[23:16] | value;
      end
      // Place the pixel; bottom-up images are flipped vertically.
      col = int'(col_cnt);
      row = int'(row_cnt);
      sx  = int'(cfg_origin_x) + col;
      sy  = (h < 0) ? int'(cfg_origin_y) + row : int'(cfg_origin_y) + ah - 1 - row;
      vis = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
      if (vis) px.write_address = bmp_fb_pkg::ADDR_W'(sy * SCREEN_W + sx);
      row_end = col + 1 >= w;
      img_end = row_end && row + 1 >= ah;
      px.argb_color = {alpha, gathered};
      px.visible    = vis;
      px.last_pixel = img_end;
      byte_pos = 2'd0;
      gathered = 24'd0;
      if (img_end) begin
         image_done = 1'b1;
      end else if (row_end) begin
         col_cnt  = 11'd0;
         row_cnt  = row_cnt + 11'd1;
         pad_left = 2'((4 - ((w * bpp) & 3)) & 3);
      end else begin
         col_cnt = col_cnt + 11'd1;
      end
      return 1'b1;
   endfunction

   // Offer one byte, with a random gap first, and predict its effect.
   task automatic send_byte(input logic [7:0] value);
      bmp_fb_pkg::result_type px;
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_gap_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (blit_byte(value, px)) expected_pixels.push_back(px);
   endtask

   // Write one header register and mirror it in the predictor.
   task automatic write_reg(input logic [bmp_fb_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bmp_fb_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         bmp_fb_pkg::REG_IMAGE_WIDTH:  cfg_width    = value[11:0];
         bmp_fb_pkg::REG_IMAGE_HEIGHT: cfg_height   = value[12:0];
         bmp_fb_pkg::REG_DEPTH_IS_32:  cfg_depth32  = value[0];
         bmp_fb_pkg::REG_ORIGIN_X:     cfg_origin_x = value[9:0];
         bmp_fb_pkg::REG_ORIGIN_Y:     cfg_origin_y = value[9:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait until every predicted pixel has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin send_gap_pct = 80; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 80; end
         IDLE_BOTH:     begin send_gap_pct = 14; stall_pct = 14; end
         default:       begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // Choose a header for a phase of n bytes. The height always leaves room
   // for more rows than the phase can finish, so the image stays open.
   task automatic pick_config(input int phase_no, input int n);
      logic [11:0] w;
      logic [12:0] h;
      logic [9:0]  ox, oy;
      int mag, pick;
      pick = $urandom_range(99);
      if (phase_no == 0) w = 12'd0;
      else if (phase_no == 1) w = 12'hFFF;
      else if (phase_no == 2) w = 12'(DIM_LIMIT);
      else if (phase_no == 3 || pick >= 25) w = 12'($urandom_range(1, 8));
      else if (pick < 5) w = 12'd0;
      else if (pick < 10) w = 12'(DIM_LIMIT);
      else w = 12'($urandom_range(9, 64));
      pick = $urandom_range(99);
      if (phase_no == 4 || (phase_no > 7 && pick < 10)) begin
         ox = 10'd1023;
         oy = 10'd1023;
      end else if (phase_no == 5 || (phase_no > 7 && pick < 30)) begin
         ox = 10'd0;
         oy = 10'd0;
      end else begin
         ox = 10'($urandom_range(0, 900));
         oy = 10'($urandom_range(0, 600));
      end
      mag = int'(row_cnt) + n / 4 + 2 + $urandom_range(0, 400);
      if (mag > DIM_LIMIT) mag = DIM_LIMIT;
      if (phase_no == 6) h = 13'h0FFF;
      else if (phase_no == 7) h = 13'h1000;
      else h = $urandom_range(1) ? 13'(-mag) : 13'(mag);
      write_reg(bmp_fb_pkg::REG_IMAGE_WIDTH, {1'($urandom()), w});
      write_reg(bmp_fb_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(bmp_fb_pkg::REG_DEPTH_IS_32, {12'($urandom()), 1'($urandom())});
      write_reg(bmp_fb_pkg::REG_ORIGIN_X, {3'($urandom()), ox});
      write_reg(bmp_fb_pkg::REG_ORIGIN_Y, {3'($urandom()), oy});
      // Now and then an index beyond the register file, which must do nothing.
      if ($urandom_range(3) == 0)
         write_reg(3'(bmp_fb_pkg::REG_ORIGIN_Y + 1 + $urandom_range(0, 2)),
                   13'($urandom()));
   endtask

   // Header defaults straight after reset: 800 wide, bottom-up, 24-bit.
   task automatic test_reset_values();
      set_idle(IDLE_NONE);
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
   endtask

   // Narrow top-down rows: a row end with three padding bytes, then
   // 32-bit pixels with extreme and sign-bit alpha values.
   task automatic test_padding_and_alpha();
      drain();
      write_reg(bmp_fb_pkg::REG_IMAGE_WIDTH, 13'd3);
      write_reg(bmp_fb_pkg::REG_IMAGE_HEIGHT, 13'h1800);
      write_reg(bmp_fb_pkg::REG_DEPTH_IS_32, 13'd0);
      write_reg(bmp_fb_pkg::REG_ORIGIN_X, 13'd0);
      write_reg(bmp_fb_pkg::REG_ORIGIN_Y, 13'd0);
      send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA);
      drain();
      write_reg(bmp_fb_pkg::REG_DEPTH_IS_32, 13'd1);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h80); send_byte(8'h7F); send_byte(8'h01); send_byte(8'h80);
   endtask

   // A height of zero makes the block drop every byte.
   task automatic test_zero_height();
      drain();
      write_reg(bmp_fb_pkg::REG_IMAGE_HEIGHT, 13'd0);
      repeat (4) send_byte(8'($urandom()));
      drain();
      write_reg(bmp_fb_pkg::REG_IMAGE_HEIGHT, 13'h1800);
   endtask

   // Phases of random bytes, each with a fresh header and idling pattern.
   task automatic test_random_phases();
      int phase_no, n;
      phase_no = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         n = $urandom_range(100, 250);
         drain();
         set_idle(idle_mode_type'(phase_no % 4));
         pick_config(phase_no, n);
         repeat (n) send_byte(8'($urandom()));
         phase_no++;
      end
      phases_run = phase_no;
   endtask

   // The receiver holds off for a long stretch while bytes keep coming,
   // so the block fills and stalls its input; then the sender waits for
   // every pixel to come out.
   task automatic test_backpressure();
      drain();
      set_idle(IDLE_NONE);
      pick_config(8, 160);
      hold_requests++;
      repeat (160) send_byte(8'($urandom()));
      drain();
   endtask

   // Close the image two rows on, then check that trailing bytes are dropped.
   task automatic test_image_end();
      int guard;
      drain();
      set_idle(IDLE_BOTH);
      write_reg(bmp_fb_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(1, 4)));
      write_reg(bmp_fb_pkg::REG_IMAGE_HEIGHT,
                $urandom_range(1) ? 13'(-(int'(row_cnt) + 2))
                                  : 13'(int'(row_cnt) + 2));
      guard = 0;
      while (!image_done && guard < 200) begin
         send_byte(8'($urandom()));
         guard++;
      end
      repeat (16) send_byte(8'($urandom()));
   endtask

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_requests != hold_grants) begin
         hold_grants <= hold_grants + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each pixel write with the oldest prediction.
   always @(posedge clock) begin : check_pixels
      bmp_fb_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected pixel write, address %h colour %h",
                     $time, rsp_tdata[bmp_fb_pkg::ADDR_W-1:0],
                     rsp_tdata[bmp_fb_pkg::ADDR_W +: bmp_fb_pkg::COLOR_W]);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_tuser) pixels_visible++;
            if (rsp_tdata[bmp_fb_pkg::ADDR_W-1:0] !== want.write_address) begin
               mismatches++;
               $display("%0t: write_address expected %h got %h",
                        $time, want.write_address, rsp_tdata[bmp_fb_pkg::ADDR_W-1:0]);
            end
            if (rsp_tdata[bmp_fb_pkg::ADDR_W +: bmp_fb_pkg::COLOR_W] !== want.argb_color) begin
               mismatches++;
               $display("%0t: argb_color expected %h got %h",
                        $time, want.argb_color,
                        rsp_tdata[bmp_fb_pkg::ADDR_W +: bmp_fb_pkg::COLOR_W]);
            end
            if (rsp_tuser !== want.visible) begin
               mismatches++;
               $display("%0t: visible expected %b got %b",
                        $time, want.visible, rsp_tuser);
            end
            if (rsp_tlast !== want.last_pixel) begin
               mismatches++;
               $display("%0t: last_pixel expected %b got %b",
                        $time, want.last_pixel, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycles <= LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_padding_and_alpha();
      test_zero_height();
      test_random_phases();
      test_backpressure();
      test_image_end();
      drain();
      $display("Streamed %0d bytes over %0d header phases; %0d pixel writes checked.",
               bytes_sent, phases_run + 3, pixels_checked);
      $display("%0d writes landed on screen; the image was closed and trailing bytes dropped.",
               pixels_visible);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/bmp_fb_pkg.sv
hw/rtl/bmp_fb_unpack.sv
hw/rtl/bmp_fb_addr.sv
hw/rtl/bmp_pixel_stream_to_framebuffer.sv
test/tb_top.sv
